// ----- rtl/hpt_pkg.sv -----
package hpt_pkg;

   localparam int MATRIX_DEPTH = 16;
   localparam int INDEX_WIDTH = 4;
   localparam int DIM = 4;
   localparam int COORDS = 3;

   typedef logic command_type;
   localparam command_type CMD_LOAD = 1'b0;
   localparam command_type CMD_TRANSFORM = 1'b1;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK = 2'd0;
   localparam status_type STATUS_INFINITY = 2'd1;
   localparam status_type STATUS_SATURATED = 2'd2;

endpackage

// ----- rtl/homogeneous_point_transform.sv -----
// Items pass stages 1-5, divider setup, divider stages and output register. Throughput: one item
// per cycle unless stalled; the perspective divide is a restoring divider unrolled into
// COORD_WIDTH + 2 register stages, one quotient bit per stage, so every stage takes a new item.
// A stalled result freezes the whole pipeline. Load items update the matrix and leave a bubble.
// Reset is synchronous: it clears all valid bits and sets the matrix to identity.
module homogeneous_point_transform #(
   parameter int COORD_WIDTH = 48,
   parameter int FRACTION_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [hpt_pkg::INDEX_WIDTH-1:0] req_entry_index,
   input  logic signed [COORD_WIDTH-1:0] req_entry_value,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z,
   output logic [1:0]                    rsp_status
);

   localparam int CW = COORD_WIDTH;
   localparam int F = FRACTION_BITS;
   localparam int LW = CW / 2;
   localparam int HW = CW - LW;
   localparam int PW = 2 * CW;
   localparam int AW = 2 * CW + 2;
   localparam int MW = AW;
   localparam int QW = CW + 2;
   localparam int DSW = MW + F + 1;
   localparam int ND = hpt_pkg::DIM;
   localparam int NC = hpt_pkg::COORDS;
   localparam logic signed [CW-1:0] ENTRY_ONE = CW'(1) << F;
   localparam logic [QW:0] LIMIT = (QW + 1)'(1) << (CW - 1);

   logic advance;
   logic req_accept;

   logic signed [CW-1:0] mat_ff [hpt_pkg::MATRIX_DEPTH];

   // Stage 1: half-width partial products.
   logic                      s1_valid_ff;
   logic signed [CW+LW:0]     s1_pl_ff [ND][NC];
   logic signed [CW+HW-1:0]   s1_ph_ff [ND][NC];
   logic signed [CW-1:0]      s1_tcol_ff [ND];
   logic signed [CW+LW:0]     s1_pl_in [ND][NC];
   logic signed [CW+HW-1:0]   s1_ph_in [ND][NC];
   logic signed [CW-1:0]      point [NC];

   // Stage 2: full products.
   logic                      s2_valid_ff;
   logic signed [PW-1:0]      s2_prod_ff [ND][NC];
   logic signed [CW-1:0]      s2_tcol_ff [ND];
   logic signed [PW-1:0]      s2_prod_in [ND][NC];

   // Stage 3 and 4: row sums.
   logic                      s3_valid_ff;
   logic signed [AW-1:0]      s3_sa_ff [ND];
   logic signed [AW-1:0]      s3_sb_ff [ND];
   logic signed [AW-1:0]      s3_sa_in [ND];
   logic signed [AW-1:0]      s3_sb_in [ND];
   logic                      s4_valid_ff;
   logic signed [AW-1:0]      s4_acc_ff [ND];

   // Stage 5: magnitudes and signs.
   logic                      s5_valid_ff;
   logic [MW-1:0]             s5_mag_ff [NC];
   logic                      s5_neg_ff [NC];
   logic [MW-1:0]             s5_den_ff;
   logic                      s5_zero_ff;
   logic [MW-1:0]             s5_mag_in [NC];
   logic                      s5_neg_in [NC];
   logic [MW-1:0]             s5_den_in;

   // Divider stages; index 0 is the setup stage.
   logic                      dv_valid_ff [QW+1];
   logic [MW-1:0]             dv_rem_ff [QW+1][NC];
   logic [QW-1:0]             dv_q_ff [QW+1][NC];
   logic [QW-1:0]             dv_dlo_ff [QW+1][NC];
   logic                      dv_ovf_ff [QW+1][NC];
   logic                      dv_neg_ff [QW+1][NC];
   logic [MW-1:0]             dv_den_ff [QW+1];
   logic                      dv_zero_ff [QW+1];
   logic [MW-1:0]             dv_rem_in [QW+1][NC];
   logic [QW-1:0]             dv_q_in [QW+1][NC];
   logic [QW-1:0]             dv_dlo_in [NC];
   logic                      dv_ovf_in [NC];

   // Output register.
   logic                      rsp_valid_ff;
   logic signed [CW-1:0]      rsp_coord_ff [NC];
   logic [1:0]                rsp_status_ff;
   logic signed [CW-1:0]      rsp_coord_in [NC];
   logic [1:0]                rsp_status_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign req_accept = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hpt_pkg::MATRIX_DEPTH; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? ENTRY_ONE : '0;
         end
      end else if (req_accept && req_command == hpt_pkg::CMD_LOAD) begin
         mat_ff[req_entry_index] <= req_entry_value;
      end
   end

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   // The point is split into an unsigned low half and a signed high half.
   always_comb begin
      for (int r = 0; r < ND; r++) begin
         for (int c = 0; c < NC; c++) begin
            s1_pl_in[r][c] = mat_ff[c * ND + r] * $signed({1'b0, point[c][LW-1:0]});
            s1_ph_in[r][c] = mat_ff[c * ND + r] * $signed(point[c][CW-1:LW]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < ND; r++) begin
         for (int c = 0; c < NC; c++) begin
            s2_prod_in[r][c] = (PW'(s1_ph_ff[r][c]) <<< LW) + PW'(s1_pl_ff[r][c]);
         end
         s3_sa_in[r] = AW'(s2_prod_ff[r][0]) + AW'(s2_prod_ff[r][1]);
         s3_sb_in[r] = AW'(s2_prod_ff[r][2]) + (AW'(s2_tcol_ff[r]) <<< F);
      end
   end

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         s5_mag_in[k] = s4_acc_ff[k][AW-1] ? MW'(-s4_acc_ff[k]) : MW'(s4_acc_ff[k]);
         s5_neg_in[k] = s4_acc_ff[k][AW-1] ^ s4_acc_ff[ND-1][AW-1];
      end
      s5_den_in = s4_acc_ff[ND-1][AW-1] ? MW'(-s4_acc_ff[ND-1]) : MW'(s4_acc_ff[ND-1]);
   end

   // Dividend is the magnitude shifted up by FRACTION_BITS + 1. Its bits above the quotient
   // width seed the remainder; if they already reach the divisor, the quotient overflows.
   always_comb begin
      logic [DSW-1:0] dsh;
      for (int k = 0; k < NC; k++) begin
         dsh = {s5_mag_ff[k], {(F + 1){1'b0}}};
         dv_dlo_in[k] = dsh[QW-1:0];
         dv_rem_in[0][k] = MW'(dsh >> QW);
         dv_q_in[0][k] = '0;
         dv_ovf_in[k] = dv_rem_in[0][k] >= s5_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid && req_command == hpt_pkg::CMD_TRANSFORM;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         dv_valid_ff[0] <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pl_ff <= s1_pl_in;
         s1_ph_ff <= s1_ph_in;
         for (int r = 0; r < ND; r++) begin
            s1_tcol_ff[r] <= mat_ff[NC * ND + r];
         end
         s2_prod_ff <= s2_prod_in;
         s2_tcol_ff <= s1_tcol_ff;
         s3_sa_ff <= s3_sa_in;
         s3_sb_ff <= s3_sb_in;
         for (int r = 0; r < ND; r++) begin
            s4_acc_ff[r] <= s3_sa_ff[r] + s3_sb_ff[r];
         end
         s5_mag_ff <= s5_mag_in;
         s5_neg_ff <= s5_neg_in;
         s5_den_ff <= s5_den_in;
         s5_zero_ff <= s4_acc_ff[ND-1] == '0;
         dv_rem_ff[0] <= dv_rem_in[0];
         dv_q_ff[0] <= dv_q_in[0];
         dv_dlo_ff[0] <= dv_dlo_in;
         dv_ovf_ff[0] <= dv_ovf_in;
         dv_neg_ff[0] <= s5_neg_ff;
         dv_den_ff[0] <= s5_den_ff;
         dv_zero_ff[0] <= s5_zero_ff;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      always_comb begin
         logic [MW:0] trial;
         for (int k = 0; k < NC; k++) begin
            trial = {dv_rem_ff[s][k], dv_dlo_ff[s][k][QW-1-s]};
            if (trial >= {1'b0, dv_den_ff[s]}) begin
               dv_rem_in[s+1][k] = MW'(trial - {1'b0, dv_den_ff[s]});
               dv_q_in[s+1][k] = {dv_q_ff[s][k][QW-2:0], 1'b1};
            end else begin
               dv_rem_in[s+1][k] = trial[MW-1:0];
               dv_q_in[s+1][k] = {dv_q_ff[s][k][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            dv_valid_ff[s+1] <= dv_valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_rem_ff[s+1] <= dv_rem_in[s+1];
            dv_q_ff[s+1] <= dv_q_in[s+1];
            dv_dlo_ff[s+1] <= dv_dlo_ff[s];
            dv_ovf_ff[s+1] <= dv_ovf_ff[s];
            dv_neg_ff[s+1] <= dv_neg_ff[s];
            dv_den_ff[s+1] <= dv_den_ff[s];
            dv_zero_ff[s+1] <= dv_zero_ff[s];
         end
      end
   end

   // Round half away from zero on the magnitude, then clamp and restore the sign.
   always_comb begin
      logic [QW:0] fin;
      logic        sat;
      logic        any_sat;
      any_sat = 1'b0;
      for (int k = 0; k < NC; k++) begin
         fin = ({1'b0, dv_q_ff[QW][k]} + (QW + 1)'(1)) >> 1;
         sat = dv_ovf_ff[QW][k] || (!dv_neg_ff[QW][k] && fin >= LIMIT)
            || (dv_neg_ff[QW][k] && fin > LIMIT);
         any_sat = any_sat || sat;
         if (dv_zero_ff[QW]) begin
            rsp_coord_in[k] = '0;
         end else if (sat) begin
            rsp_coord_in[k] = dv_neg_ff[QW][k] ? {1'b1, {(CW - 1){1'b0}}}
               : {1'b0, {(CW - 1){1'b1}}};
         end else if (dv_neg_ff[QW][k]) begin
            rsp_coord_in[k] = -fin[CW-1:0];
         end else begin
            rsp_coord_in[k] = fin[CW-1:0];
         end
      end
      if (dv_zero_ff[QW]) begin
         rsp_status_in = hpt_pkg::STATUS_INFINITY;
      end else if (any_sat) begin
         rsp_status_in = hpt_pkg::STATUS_SATURATED;
      end else begin
         rsp_status_in = hpt_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_coord_ff <= rsp_coord_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_coord_ff[0];
   assign rsp_out_y = rsp_coord_ff[1];
   assign rsp_out_z = rsp_coord_ff[2];
   assign rsp_status = rsp_status_ff;

endmodule
